/* rtl/core/dtr_pkg.sv */
// ----------------------------------------------------------------------------
// dtr_pkg: shared types and constants of the divider timer
// Operation codes, register addresses, controller/datapath interface structs.
// ----------------------------------------------------------------------------
package dtr_pkg;

    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CTRL_W   = 3;
    localparam int unsigned FUNC_W   = 2;
    // counter prescale plus one tick of cycles stays below 2048
    localparam int unsigned ACC_W    = 11;

    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam logic [ADDR_W-1:0] ADDR_DIV  = 16'hFF04;
    localparam logic [ADDR_W-1:0] ADDR_TIMA = 16'hFF05;
    localparam logic [ADDR_W-1:0] ADDR_TMA  = 16'hFF06;
    localparam logic [ADDR_W-1:0] ADDR_TAC  = 16'hFF07;

    localparam logic [BYTE_W-1:0] UNMAPPED_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] COUNT_MAX     = 8'hFF;
    localparam int unsigned       TAC_EN_BIT    = 2;

    localparam logic [1:0] SEL_1024 = 2'd0;
    localparam logic [1:0] SEL_16   = 2'd1;
    localparam logic [1:0] SEL_64   = 2'd2;
    localparam logic [1:0] SEL_256  = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // input item taken this cycle
        logic step;     // one counter period worked off
        logic finish;   // tick result goes to the output register
    } dtr_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic in_tick;       // pending input item is a tick
        logic step_pending;  // prescale still at or past the period
        logic out_free;      // output register can take a result
    } dtr_status_t;

    function automatic logic [ACC_W-1:0] period_of(input logic [1:0] sel);
        logic [ACC_W-1:0] p;
        case (sel)
            SEL_16:  p = 11'd16;
            SEL_64:  p = 11'd64;
            SEL_256: p = 11'd256;
            default: p = 11'd1024;
        endcase
        return p;
    endfunction

endpackage

/* rtl/core/dtr_ctrl.sv */
// ----------------------------------------------------------------------------
// dtr_ctrl: sequencing controller of the divider timer
// Accepts items, runs the counter step loop of a tick, hands off results.
// ----------------------------------------------------------------------------
module dtr_ctrl
    import dtr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  dtr_status_t status,
    output dtr_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE) && status.out_free;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_tvalid && s_tready;
                if (cmd.accept && status.in_tick) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (status.step_pending) begin
                    cmd.step = 1'b1;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // wait for the output register to drain
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_step_only_running: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |=> (state_reg == ST_RUN) || (state_reg == ST_FIN))
        else $error("counter step outside the tick loop");
    a_tick_enters_loop: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && status.in_tick) |=> (state_reg == ST_RUN))
        else $error("tick item did not start the step loop");
    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept, cmd.step, cmd.finish}))
        else $error("controller issued overlapping commands");
`endif

endmodule

/* rtl/core/dtr_datapath.sv */
// ----------------------------------------------------------------------------
// dtr_datapath: timer registers, prescalers and output register
// Bus read/write decode, divider update, one counter step per command.
// ----------------------------------------------------------------------------
module dtr_datapath
    import dtr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [FUNC_W-1:0]  func,
    input  logic [ADDR_W-1:0]  bus_address,
    input  logic [BYTE_W-1:0]  write_data,
    input  logic [BYTE_W-1:0]  elapsed_cycles,
    input  dtr_cmd_t           cmd,
    output dtr_status_t        status,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [BYTE_W-1:0]  read_data,
    output logic               irq_request
);

    logic [BYTE_W-1:0] div_val_reg, div_val_next;
    logic [BYTE_W-1:0] cnt_val_reg, cnt_val_next;
    logic [BYTE_W-1:0] mod_val_reg, mod_val_next;
    logic [CTRL_W-1:0] ctrl_reg, ctrl_next;
    logic [BYTE_W-1:0] div_pre_reg, div_pre_next;
    logic [ACC_W-1:0]  cnt_acc_reg, cnt_acc_next;
    logic              irq_reg, irq_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_rd_reg, out_rd_next;
    logic              out_irq_reg, out_irq_next;

    logic [ACC_W-1:0]  period;
    logic [BYTE_W:0]   div_sum;
    logic [BYTE_W-1:0] rd_mux;

    assign period  = period_of(ctrl_reg[1:0]);
    assign div_sum = {1'b0, div_pre_reg} + {1'b0, elapsed_cycles};

    assign status.in_tick      = (func == FUNC_TICK);
    assign status.step_pending = ctrl_reg[TAC_EN_BIT] && (cnt_acc_reg >= period);
    assign status.out_free     = !out_valid_reg || m_tready;

    always_comb begin
        unique case (bus_address)
            ADDR_DIV:  rd_mux = div_val_reg;
            ADDR_TIMA: rd_mux = cnt_val_reg;
            ADDR_TMA:  rd_mux = mod_val_reg;
            ADDR_TAC:  rd_mux = {{(BYTE_W-CTRL_W){1'b0}}, ctrl_reg};
            default:   rd_mux = UNMAPPED_BYTE;
        endcase
    end

    always_comb begin
        div_val_next   = div_val_reg;
        cnt_val_next   = cnt_val_reg;
        mod_val_next   = mod_val_reg;
        ctrl_next      = ctrl_reg;
        div_pre_next   = div_pre_reg;
        cnt_acc_next   = cnt_acc_reg;
        irq_next       = irq_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_rd_next    = out_rd_reg;
        out_irq_next   = out_irq_reg;

        if (cmd.accept) begin
            unique case (func)
                FUNC_READ: begin
                    out_valid_next = 1'b1;
                    out_rd_next    = rd_mux;
                    out_irq_next   = 1'b0;
                end
                FUNC_WRITE: begin
                    unique case (bus_address)
                        ADDR_DIV: begin
                            div_val_next = '0;
                            div_pre_next = '0;
                        end
                        ADDR_TIMA: cnt_val_next = write_data;
                        ADDR_TMA:  mod_val_next = write_data;
                        ADDR_TAC:  ctrl_next    = write_data[CTRL_W-1:0];
                        default: begin
                        end
                    endcase
                    out_valid_next = 1'b1;
                    out_rd_next    = '0;
                    out_irq_next   = 1'b0;
                end
                FUNC_TICK: begin
                    // prescale below 256 plus one byte: at most one divider step
                    div_pre_next = div_sum[BYTE_W-1:0];
                    if (div_sum[BYTE_W]) begin
                        div_val_next = div_val_reg + 8'd1;
                    end
                    // counter prescale is held while the timer is disabled
                    if (ctrl_reg[TAC_EN_BIT]) begin
                        cnt_acc_next = cnt_acc_reg + {{(ACC_W-BYTE_W){1'b0}}, elapsed_cycles};
                    end
                    irq_next = 1'b0;
                end
                FUNC_UNUSED: begin
                    out_valid_next = 1'b1;
                    out_rd_next    = '0;
                    out_irq_next   = 1'b0;
                end
                default: begin
                end
            endcase
        end else if (cmd.step) begin
            cnt_acc_next = cnt_acc_reg - period;
            if (cnt_val_reg == COUNT_MAX) begin
                cnt_val_next = mod_val_reg;
                irq_next     = 1'b1;
            end else begin
                cnt_val_next = cnt_val_reg + 8'd1;
            end
        end else if (cmd.finish) begin
            out_valid_next = 1'b1;
            out_rd_next    = '0;
            out_irq_next   = irq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_val_reg   <= '0;
            cnt_val_reg   <= '0;
            mod_val_reg   <= '0;
            ctrl_reg      <= '0;
            div_pre_reg   <= '0;
            cnt_acc_reg   <= '0;
            irq_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            div_val_reg   <= div_val_next;
            cnt_val_reg   <= cnt_val_next;
            mod_val_reg   <= mod_val_next;
            ctrl_reg      <= ctrl_next;
            div_pre_reg   <= div_pre_next;
            cnt_acc_reg   <= cnt_acc_next;
            irq_reg       <= irq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_rd_reg  <= out_rd_next;
        out_irq_reg <= out_irq_next;
    end

    assign m_tvalid    = out_valid_reg;
    assign read_data   = out_rd_reg;
    assign irq_request = out_irq_reg;

`ifndef SYNTHESIS
    a_direct_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && !status.in_tick) |=> m_tvalid)
        else $error("read or write item gave no result");
    a_finish_after_loop: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !status.step_pending)
        else $error("tick finished with counter periods left");
    a_irq_no_read_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && irq_request) |-> (read_data == '0))
        else $error("interrupt result carries read data");
    a_counter_idle_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (!cmd.accept && !cmd.step) |=> $stable(cnt_val_reg))
        else $error("counter moved without a step or write");
    a_prescale_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (cnt_acc_reg < 11'd1024))
        else $error("counter prescale left at or above its range");
`endif

endmodule

/* rtl/core/divider_timer_with_reload_core.sv */
// ----------------------------------------------------------------------------
// divider_timer_with_reload_core: divider and reloading counter timer
// Four byte registers on a 16-bit bus, advanced by ticks of machine cycles.
// ----------------------------------------------------------------------------
// Each input item is a bus read, a bus write or a tick (kind in s_tuser) and
// gives exactly one result item. A read or write result is registered in the
// cycle after the item is taken. A tick runs the step loop, which works off one
// counter period per cycle for each counter step the tick causes (none while
// the timer is disabled), then hands its result to the output register once
// it is free. A new item is taken once the controller is idle and the output
// register is empty or hands its result on in the same cycle.
module divider_timer_with_reload_core
    import dtr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] bus_address, [23:16] write_data, [31:24] elapsed_cycles
    input  logic [31:0] s_tdata,
    // [1:0] func
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data, [8] irq_request, [15:9] zero
    output logic [15:0] m_tdata
);

    dtr_cmd_t          cmd;
    dtr_status_t       status;
    logic [BYTE_W-1:0] read_data;
    logic              irq_request;

    dtr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dtr_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .func           (s_tuser),
        .bus_address    (s_tdata[15:0]),
        .write_data     (s_tdata[23:16]),
        .elapsed_cycles (s_tdata[31:24]),
        .cmd            (cmd),
        .status         (status),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .read_data      (read_data),
        .irq_request    (irq_request)
    );

    assign m_tdata = {7'd0, irq_request, read_data};

endmodule
